// File: hw/rtl/qoie_pkg.sv
// Shared types, constants and the hash function of the QOI image encoder.
`timescale 1ns / 1ps
`default_nettype none

package qoie_pkg;

    // Seen-pixel table.
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    // Run handling: a run is flushed at this many pixels.
    localparam int RUN_W     = 6;
    localparam int RUN_LIMIT = 62;

    // Chunk tags.
    localparam logic [7:0] TAG_INDEX = 8'h00;
    localparam logic [7:0] TAG_DIFF  = 8'h40;
    localparam logic [7:0] TAG_LUMA  = 8'h80;
    localparam logic [7:0] TAG_RUN   = 8'hC0;
    localparam logic [7:0] TAG_RGB   = 8'hFE;
    localparam logic [7:0] TAG_RGBA  = 8'hFF;

    // Previous pixel at the start of an image: black, opaque.
    localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

    // Byte counts.
    localparam int CHUNK_MAX = 5;
    localparam int CLEN_W    = 3;
    localparam int END_BYTES = 8;
    localparam int POS_W     = 4;

    // Queue between the classifier and the byte emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One input pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
    } pixel_t;

    // One byte of the coded stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } code_t;

    // Everything one pixel emits: an optional run byte, a chunk of up to five
    // bytes and an optional end marker, in that order.
    typedef struct packed {
        logic                           run_vld;
        logic [7:0]                     run_byte;
        logic [CLEN_W-1:0]              chunk_len;
        logic [CHUNK_MAX-1:0][7:0]      chunk;
        logic                           end_mark;
    } op_t;

    // Hash slot (3r + 5g + 7b + 11a) mod 64; only the low six bits matter.
    function automatic logic [SLOT_W-1:0] hash_slot(input logic [31:0] pix);
        logic [SLOT_W-1:0] r6;
        logic [SLOT_W-1:0] g6;
        logic [SLOT_W-1:0] b6;
        logic [SLOT_W-1:0] a6;
        r6 = pix[24 +: SLOT_W];
        g6 = pix[16 +: SLOT_W];
        b6 = pix[8 +: SLOT_W];
        a6 = pix[0 +: SLOT_W];
        return r6 * SLOT_W'(3) + g6 * SLOT_W'(5) + b6 * SLOT_W'(7) + a6 * SLOT_W'(11);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qoie_front.sv
// Front end: accepts pixels, tracks runs and the seen table, classifies chunks.
`timescale 1ns / 1ps
`default_nettype none

module qoie_front
    import qoie_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    input  wire logic   push,
    output logic        full,
    input  wire pixel_t pixel,
    input  wire logic   q_full,
    output logic        q_push,
    output op_t         q_op
);

    // Control state.
    logic                     alpha_mode_reg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [31:0]              prev_reg;
    logic [31:0]              prev_next;
    logic [RUN_W-1:0]         run_reg;
    logic [RUN_W-1:0]         run_next;
    logic [TABLE_ENTRIES-1:0] vbits_reg;
    logic [TABLE_ENTRIES-1:0] vbits_next;

    // Stage payload.
    logic [31:0]              s1_pix_reg;
    logic                     s1_last_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic [31:0]              rd_data_reg;
    logic                     byp_reg;
    logic [31:0]              byp_data_reg;
    logic                     tab_vld_reg;

    logic [31:0]              seen_mem [TABLE_ENTRIES];

    logic [31:0]              in_pix;
    logic [SLOT_W-1:0]        in_slot;
    logic                     accept;
    logic                     commit;
    logic                     needs_out;
    logic [7:0]               pa;
    logic [31:0]              prev_eff;
    logic                     same;
    logic [RUN_W-1:0]         run_inc;
    logic [RUN_W-1:0]         run_len;
    logic [RUN_W-1:0]         run_after;
    logic                     run_vld;
    logic [31:0]              tab_data;
    logic                     tab_hit;
    logic                     tab_we;
    logic [7:0]               dr_u;
    logic [7:0]               dg_u;
    logic [7:0]               db_u;
    logic signed [7:0]        dr;
    logic signed [7:0]        dg;
    logic signed [7:0]        db;
    logic signed [8:0]        drg;
    logic signed [8:0]        dbg;
    logic [7:0]               dr2;
    logic [7:0]               dg2;
    logic [7:0]               db2;
    logic [7:0]               dg32;
    logic [7:0]               drg8;
    logic [7:0]               dbg8;
    op_t                      op;

    assign in_pix  = {pixel.red, pixel.green, pixel.blue,
                      alpha_mode_reg ? pixel.alpha : 8'hFF};
    assign in_slot = hash_slot(in_pix);

    // Previous pixel as seen in the current mode.
    assign pa       = alpha_mode_reg ? prev_reg[7:0] : 8'hFF;
    assign prev_eff = {prev_reg[31:8], pa};
    assign same     = (s1_pix_reg == prev_eff);

    // Run bookkeeping.
    assign run_inc = run_reg + RUN_W'(1);
    always_comb
    begin
        if (same)
        begin
            run_len   = run_inc;
            run_vld   = (run_inc == RUN_W'(RUN_LIMIT)) || s1_last_reg;
            run_after = (run_inc == RUN_W'(RUN_LIMIT)) ? '0 : run_inc;
        end
        else
        begin
            run_len   = run_reg;
            run_vld   = (run_reg != '0);
            run_after = '0;
        end
    end

    // An entry not written since the image began holds zero.
    assign tab_data = byp_reg ? byp_data_reg : rd_data_reg;
    assign tab_hit  = ((tab_vld_reg ? tab_data : 32'h0) == s1_pix_reg);

    // Channel differences, wrapped to 8 bits.
    assign dr_u = s1_pix_reg[31:24] - prev_eff[31:24];
    assign dg_u = s1_pix_reg[23:16] - prev_eff[23:16];
    assign db_u = s1_pix_reg[15:8]  - prev_eff[15:8];
    assign dr   = signed'(dr_u);
    assign dg   = signed'(dg_u);
    assign db   = signed'(db_u);
    assign drg  = 9'(dr) - 9'(dg);
    assign dbg  = 9'(db) - 9'(dg);
    assign dr2  = dr_u + 8'd2;
    assign dg2  = dg_u + 8'd2;
    assign db2  = db_u + 8'd2;
    assign dg32 = dg_u + 8'd32;
    assign drg8 = dr_u - dg_u + 8'd8;
    assign dbg8 = db_u - dg_u + 8'd8;

    always_comb
    begin
        op           = '0;
        op.run_vld   = run_vld;
        op.run_byte  = TAG_RUN | {2'b00, run_len - RUN_W'(1)};
        op.end_mark  = s1_last_reg;
        if (!same)
        begin
            if (tab_hit)
            begin
                op.chunk_len = CLEN_W'(1);
                op.chunk[0]  = TAG_INDEX | {2'b00, s1_slot_reg};
            end
            else if (s1_pix_reg[7:0] != pa)
            begin
                op.chunk_len = CLEN_W'(5);
                op.chunk[0]  = TAG_RGBA;
                op.chunk[1]  = s1_pix_reg[31:24];
                op.chunk[2]  = s1_pix_reg[23:16];
                op.chunk[3]  = s1_pix_reg[15:8];
                op.chunk[4]  = s1_pix_reg[7:0];
            end
            else if (dr >= -8'sd2 && dr <= 8'sd1 && dg >= -8'sd2 && dg <= 8'sd1 &&
                     db >= -8'sd2 && db <= 8'sd1)
            begin
                op.chunk_len = CLEN_W'(1);
                op.chunk[0]  = TAG_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
            end
            else if (dg >= -8'sd32 && dg <= 8'sd31 && drg >= -9'sd8 && drg <= 9'sd7 &&
                     dbg >= -9'sd8 && dbg <= 9'sd7)
            begin
                op.chunk_len = CLEN_W'(2);
                op.chunk[0]  = TAG_LUMA | {2'b00, dg32[5:0]};
                op.chunk[1]  = {drg8[3:0], dbg8[3:0]};
            end
            else
            begin
                op.chunk_len = CLEN_W'(4);
                op.chunk[0]  = TAG_RGB;
                op.chunk[1]  = s1_pix_reg[31:24];
                op.chunk[2]  = s1_pix_reg[23:16];
                op.chunk[3]  = s1_pix_reg[15:8];
            end
        end
    end

    // A pixel that only extends a run produces nothing and never waits.
    assign needs_out = op.run_vld || (op.chunk_len != '0) || op.end_mark;
    assign commit    = s1_valid_reg && (!needs_out || !q_full);
    assign full      = s1_valid_reg && !commit;
    assign accept    = push && !full;
    assign q_push    = commit && needs_out;
    assign q_op      = op;
    assign tab_we    = commit && !same && !tab_hit;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_reg);
        prev_next     = prev_reg;
        run_next      = run_reg;
        vbits_next    = vbits_reg;
        if (commit)
        begin
            if (s1_last_reg)
            begin
                prev_next  = PREV_RESET;
                run_next   = '0;
                vbits_next = '0;
            end
            else
            begin
                prev_next = s1_pix_reg;
                run_next  = run_after;
                if (tab_we)
                begin
                    vbits_next[s1_slot_reg] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
            prev_reg       <= PREV_RESET;
            run_reg        <= '0;
            vbits_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                alpha_mode_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
            prev_reg     <= prev_next;
            run_reg      <= run_next;
            vbits_reg    <= vbits_next;
        end
    end

    // Table lookup for the incoming pixel, with forwarding of the write made
    // by the pixel that leaves the stage at the same edge.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= in_pix;
            s1_last_reg  <= pixel.last_pixel;
            s1_slot_reg  <= in_slot;
            byp_reg      <= tab_we && (s1_slot_reg == in_slot);
            byp_data_reg <= s1_pix_reg;
            if (commit && s1_last_reg)
            begin
                tab_vld_reg <= 1'b0;
            end
            else if (tab_we && (s1_slot_reg == in_slot))
            begin
                tab_vld_reg <= 1'b1;
            end
            else
            begin
                tab_vld_reg <= vbits_reg[in_slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            seen_mem[s1_slot_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            rd_data_reg <= seen_mem[in_slot];
        end
    end

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg < RUN_W'(RUN_LIMIT))
        else $error("run length reached the flush limit without a flush");

    a_image_end: assert property (@(posedge clk) disable iff (!rst_n)
        commit && s1_last_reg |=> run_reg == '0 && prev_reg == PREV_RESET && vbits_reg == '0)
        else $error("image state not cleared after the last pixel");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !commit |=> s1_valid_reg && $stable(s1_pix_reg))
        else $error("stalled pixel lost or changed");

endmodule

`default_nettype wire

// File: hw/rtl/qoie_queue.sv
// Short queue of chunk descriptors between the classifier and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none

module qoie_queue
    import qoie_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire op_t  wr_data,
    output logic      full,
    input  wire logic rd_en,
    output op_t       rd_data,
    output logic      empty
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/qoie_back.sv
// Back end: expands chunk descriptors into stream bytes, one byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module qoie_back
    import qoie_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire op_t  q_op,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output code_t     code
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    code_t            out_reg;

    logic [POS_W-1:0] total;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] e;
    logic [7:0]       cur_byte;
    logic             byte_last;
    logic             advance;

    assign total = POS_W'(q_op.run_vld) + POS_W'(q_op.chunk_len)
                 + (q_op.end_mark ? POS_W'(END_BYTES) : '0);
    assign k     = pos_reg - POS_W'(q_op.run_vld);
    assign e     = k - POS_W'(q_op.chunk_len);

    // Byte order: run byte, chunk bytes, then the end marker 00 x7, 01.
    always_comb
    begin
        if (q_op.run_vld && pos_reg == '0)
        begin
            cur_byte = q_op.run_byte;
        end
        else if (k < POS_W'(q_op.chunk_len))
        begin
            cur_byte = q_op.chunk[k[CLEN_W-1:0]];
        end
        else if (e == POS_W'(END_BYTES - 1))
        begin
            cur_byte = 8'h01;
        end
        else
        begin
            cur_byte = 8'h00;
        end
    end

    assign byte_last      = (pos_reg == total - POS_W'(1));
    assign advance        = !q_empty && (!out_valid_reg || pop);
    assign q_pop          = advance && byte_last;
    assign pos_next       = advance ? (byte_last ? '0 : pos_reg + POS_W'(1)) : pos_reg;
    assign out_valid_next = advance || (out_valid_reg && !pop);
    assign empty          = !out_valid_reg;
    assign code           = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte  <= cur_byte;
            out_reg.last_byte <= byte_last;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> pos_reg < total)
        else $error("byte position beyond the descriptor length");

    a_mid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != '0 |-> !q_empty)
        else $error("byte position set with no descriptor waiting");

    a_keep_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !byte_last |=> !q_empty && pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("descriptor left before all of its bytes were sent");

endmodule

`default_nettype wire

// File: hw/rtl/qoi_image_encoder.sv
// Top level of the QOI image encoder: classifier, descriptor queue, byte emitter.
//
//   Channel   Direction  Handshake              Payload
//   pixel     in         push / full            pixel_t: red, green, blue, alpha, last_pixel
//   code      out        empty / pop            code_t: out_byte, last_byte
//   config    in         cfg_we                 cfg_wdata = alpha_mode
//
// The front accepts one pixel per cycle whenever its stage is free; a pixel
// is held in the stage register until its descriptor, if any, is queued, so pixels
// stream back to back while the queue has room. The back emits one byte per
// cycle from its output register while descriptors wait and the consumer pops, so
// the sustained rate is set by the byte count: at most fourteen bytes for a pixel that ends an image.
// The four-entry descriptor queue lets the two sides stall independently; full
// rises only when the queue is full and the staged pixel must emit bytes.
// Reset is asynchronous, active low, and takes effect at once: the seen table
// is marked empty through per-entry valid bits, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module qoi_image_encoder
    import qoie_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    input  wire logic   push,
    output logic        full,
    input  wire pixel_t pixel,
    output logic        empty,
    input  wire logic   pop,
    output code_t       code
);

    // Descriptor path between the front and the back.
    logic q_full;
    logic q_push;
    op_t  q_wr_op;
    logic q_empty;
    logic q_pop;
    op_t  q_rd_op;

    // The front holds the mode register, the previous pixel, the run counter
    // and the seen table, and turns each pixel that emits bytes into one descriptor.
    qoie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_wr_op)
    );

    // Descriptors wait here until the back has sent the bytes before them.
    qoie_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_op),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_op),
        .empty   (q_empty)
    );

    // The back walks each descriptor one byte per transfer and marks the
    // final byte of every descriptor.
    qoie_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (q_rd_op),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .code    (code)
    );

endmodule

`default_nettype wire
